### rtl/ros_pkg.sv
// Shared types, codes and the draw-order key comparison for the render order sorter.
package ros_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 32;
  localparam int MAX_RESULTS = 32;
  localparam int S_DATA_W = 160;
  localparam int M_DATA_W = 16;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_EMIT  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    AXIS_NONE  = 2'd0,
    AXIS_X     = 2'd1,
    AXIS_Y     = 2'd2,
    AXIS_SPARE = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    REG_PRIMARY_SEL   = 2'd0,
    REG_SECONDARY_SEL = 2'd1,
    REG_PRIMARY_ASC   = 2'd2,
    REG_SECONDARY_ASC = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        item_type;
    logic [15:0] handle;
    logic [15:0] layer;
    logic [15:0] layer_order;
    logic [31:0] primary_key;
    logic [31:0] secondary_key;
    logic [7:0]  component;
    logic [31:0] instance_id;
  } entry_t;

  typedef struct packed {
    logic primary_on;
    logic secondary_on;
    logic primary_asc;
    logic secondary_asc;
  } sort_cfg_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  typedef struct packed {
    logic add;
    logic clear;
    logic emit_start;
    logic scan_start;
    logic scan_step;
    logic out_take;
  } ros_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic last_item;
  } ros_status_t;

  function automatic logic axis_valid(input logic [1:0] sel);
    return (sel == AXIS_X) || (sel == AXIS_Y);
  endfunction

  function automatic logic [31:0] pick_key(input logic [1:0] sel, input logic item_type,
                                           input logic [31:0] x, input logic [31:0] y);
    logic [31:0] k;
    k = '0;
    if (!item_type) begin
      if (sel == AXIS_X) k = x;
      else if (sel == AXIS_Y) k = y;
    end
    return k;
  endfunction

  // Compares a against b on every key; the entry position is handled by the caller.
  function automatic cmp_t key_cmp(input entry_t a, input entry_t b, input sort_cfg_t c);
    cmp_t r;
    logic axis_on;
    axis_on = c.primary_on || c.secondary_on;
    r.lt = 1'b0;
    r.eq = 1'b0;
    if (a.layer != b.layer) begin
      r.lt = $signed(a.layer) < $signed(b.layer);
    end else if (a.layer_order != b.layer_order) begin
      r.lt = $signed(a.layer_order) < $signed(b.layer_order);
    end else if (axis_on && (a.primary_key != b.primary_key)) begin
      r.lt = ($signed(a.primary_key) < $signed(b.primary_key)) == c.primary_asc;
    end else if (axis_on && (a.secondary_key != b.secondary_key)) begin
      r.lt = ($signed(a.secondary_key) < $signed(b.secondary_key)) == c.secondary_asc;
    end else if (a.component != b.component) begin
      r.lt = a.component < b.component;
    end else if (a.instance_id != b.instance_id) begin
      r.lt = a.instance_id < b.instance_id;
    end else begin
      r.eq = 1'b1;
    end
    return r;
  endfunction

endpackage

### rtl/ros_ctrl.sv
// Controller state machine for the render order sorter.
module ros_ctrl import ros_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_kind,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  ros_status_t status,
  output ros_cmd_t    cmd
);

  state_t state, state_next;
  logic   s_fire;

  assign s_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire && (s_kind == KIND_EMIT) && !status.count_zero) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) state_next = status.last_item ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_fire) begin
          cmd.add   = (s_kind == KIND_ADD);
          cmd.clear = (s_kind == KIND_CLEAR);
          if ((s_kind == KIND_EMIT) && !status.count_zero) begin
            cmd.emit_start = 1'b1;
            cmd.scan_start = 1'b1;
          end
        end
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd.out_take   = 1'b1;
          cmd.scan_start = !status.last_item;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/ros_datapath.sv
// Item store, configuration registers and minimum-search datapath of the sorter.
module ros_datapath import ros_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ros_cmd_t           cmd,
  output ros_status_t        status,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data,
  output logic               out_type,
  output logic [15:0]        out_handle,
  output logic               out_last
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t new_entry;
  entry_t rd_data;
  entry_t best, prev;
  logic [IW-1:0] best_idx, prev_idx, pipe_idx;
  logic best_v, prev_v, pipe_v;
  logic [CW-1:0] count, scan_addr, emitted, emit_n;
  logic [1:0] primary_sel, secondary_sel;
  logic primary_asc, secondary_asc;
  sort_cfg_t scfg;
  cmp_t cmp_prev, cmp_best;
  logic after_prev, before_best, rd_en;

  assign new_entry.item_type     = s_tdata[0];
  assign new_entry.handle        = s_tdata[16:1];
  assign new_entry.layer         = s_tdata[32:17];
  assign new_entry.layer_order   = s_tdata[48:33];
  assign new_entry.primary_key   = pick_key(primary_sel, s_tdata[0], s_tdata[80:49],
                                            s_tdata[112:81]);
  assign new_entry.secondary_key = pick_key(secondary_sel, s_tdata[0], s_tdata[80:49],
                                            s_tdata[112:81]);
  assign new_entry.component     = s_tdata[120:113];
  assign new_entry.instance_id   = s_tdata[152:121];

  assign scfg.primary_on    = axis_valid(primary_sel);
  assign scfg.secondary_on  = axis_valid(secondary_sel);
  assign scfg.primary_asc   = primary_asc;
  assign scfg.secondary_asc = secondary_asc;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_sel   <= AXIS_NONE;
      secondary_sel <= AXIS_NONE;
      primary_asc   <= 1'b1;
      secondary_asc <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRIMARY_SEL:   primary_sel   <= cfg_data;
        REG_SECONDARY_SEL: secondary_sel <= cfg_data;
        REG_PRIMARY_ASC:   primary_asc   <= cfg_data[0];
        REG_SECONDARY_ASC: secondary_asc <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && (count != CW'(QUEUE_DEPTH))) mem[count[IW-1:0]] <= new_entry;
    if (rd_en) rd_data <= mem[scan_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.add && (count != CW'(QUEUE_DEPTH))) begin
      count <= count + 1'b1;
    end
  end

  always_comb begin
    if (int'(count) > MAX_RESULTS) emit_n = CW'(MAX_RESULTS);
    else                           emit_n = count;
  end

  assign rd_en = cmd.scan_step && (scan_addr != count);

  // A candidate qualifies when it lies strictly after the last emitted item and before the
  // current best; the entry position breaks full ties, which keeps arrival order.
  assign cmp_prev    = key_cmp(prev, rd_data, scfg);
  assign cmp_best    = key_cmp(rd_data, best, scfg);
  assign after_prev  = !prev_v || cmp_prev.lt || (cmp_prev.eq && (prev_idx < pipe_idx));
  assign before_best = !best_v || cmp_best.lt || (cmp_best.eq && (pipe_idx < best_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      pipe_v    <= 1'b0;
      best_v    <= 1'b0;
      prev_v    <= 1'b0;
      emitted   <= '0;
    end else begin
      if (cmd.scan_start) begin
        scan_addr <= '0;
        pipe_v    <= 1'b0;
        best_v    <= 1'b0;
      end else if (cmd.scan_step) begin
        pipe_v <= rd_en;
        if (rd_en) scan_addr <= scan_addr + 1'b1;
        if (pipe_v && after_prev && before_best) best_v <= 1'b1;
      end
      if (cmd.emit_start) begin
        prev_v  <= 1'b0;
        emitted <= '0;
      end else if (cmd.out_take) begin
        prev_v  <= 1'b1;
        emitted <= emitted + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && rd_en) pipe_idx <= scan_addr[IW-1:0];
    if (cmd.scan_step && pipe_v && after_prev && before_best) begin
      best     <= rd_data;
      best_idx <= pipe_idx;
    end
    if (cmd.out_take) begin
      prev     <= best;
      prev_idx <= best_idx;
    end
  end

  assign status.count_zero = (count == '0);
  assign status.scan_done  = (scan_addr == count) && !pipe_v;
  assign status.last_item  = (emitted + 1'b1) == emit_n;

  assign out_type   = best.item_type;
  assign out_handle = best.handle;
  assign out_last   = status.last_item;

endmodule

### rtl/render_order_sorter_top.sv
// Top level of the render order sorter: controller and datapath.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tuser kind, s_tdata item fields
//  m_*       out        m_tvalid / m_tready  m_tuser out_type, m_tdata handle, m_tlast
//  cfg_*     in         cfg_we               cfg_index, cfg_data
//
// Add and clear complete at their handshake. An emit of n stored items gives each result
// after a scan of the whole queue through the single read port of the item memory, then
// offers it on the output; the next scan starts only once that result is taken.
// Reset empties the queue at once; the memory is not cleared. Input is taken only while no
// emit is in progress, and a stalled result holds until taken.
module render_order_sorter_top import ros_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // item_type, item_handle, layer, layer_order,
                                        // position_x, position_y, component_index,
                                        // instance_id, zero fill
  input  logic [1:0]          s_tuser,  // kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // out_handle
  output logic                m_tuser,  // out_type
  output logic                m_tlast,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [1:0]          cfg_data
);

  ros_cmd_t    cmd;
  ros_status_t status;

  ros_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_kind   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ros_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .s_tdata    (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_type   (m_tuser),
    .out_handle (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

### rtl/ros_checker.sv
// Port-level checks for the render order sorter, bound to the top level.
module ros_checker import ros_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [1:0]          s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tlast
);

  // A stalled result keeps its handle and its last flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Input is never taken while a result is on offer.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  // No result straight out of reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result after reset");

  // An add or a clear causes no result.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && ((s_tuser == KIND_ADD) || (s_tuser == KIND_CLEAR))
    |=> !m_tvalid)
    else $error("result after add or clear");

endmodule

bind render_order_sorter_top ros_checker u_ros_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
